/* src/htlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_pkg: shared definitions for the linear-probe hash table
// Constants, codes and the slot record used by the table engine.
// ----------------------------------------------------------------------------
package htlp_pkg;

	// Default table depth and the longest key that may be stored
	localparam int TABLE_DEPTH_DEF = 64;
	localparam logic [4:0] MAX_KEY_BYTES = 5'd16;

	// FNV-1a constants
	localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

	// Request kinds
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_LONG = 2'd3;

	// One table row
	typedef struct packed {
		logic [31:0] value;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [4:0]  key_length;
		logic [31:0] hash;
	} slot_t;

endpackage

/* src/hash_table_linear_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_linear_probe: key-value table with FNV-1a hashing
// Get and set requests on keys of up to sixteen bytes, linear probing
// without wrap-around, one row memory holding value, key, length and hash.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table once to empty every slot, with
// s_tready low. A request is then taken only while the block is idle and is
// handled alone: a step to take it, one step per key byte through the shared
// FNV multiplier and one more to close the hash, remainder reduction four
// hash bits at a time when TABLE_DEPTH is not a power of two, a registered
// memory read and then a compare for each probed slot, and a last step to
// hand over the response once the output register is free. A set with a
// zero value or a key longer than 16 bytes, and a get with an over-long key,
// skip hashing and probing and go straight to the hand-over. The response
// waits in an output register until taken.
module hash_table_linear_probe #(
	parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// request: key_low[63:0], key_high[127:64], key_length[132:128],
	// value[164:133], zero fill [167:165]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,
	// request kind: operation[0]
	input  logic         s_tuser,
	// response: found[0], read_value[32:1], status[34:33], zero fill [39:35]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam bit POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// Keep the first n bytes of a word
	function automatic logic [63:0] byte_mask(input logic [4:0] n);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (n > 5'(i)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	logic [2:0]       state_q;
	logic [CNT_W-1:0] idx_q;
	logic [4:0]       cnt_q;
	logic [2:0]       mcnt_q;
	logic [IDX_W-1:0] rem_q;
	logic [31:0]      hs_q;
	logic             op_q;
	logic [63:0]      lo_q;
	logic [63:0]      hi_q;
	logic [4:0]       len_q;
	logic [31:0]      val_q;
	logic [31:0]      h_q;
	logic             res_found_q;
	logic [31:0]      res_value_q;
	logic [1:0]       res_status_q;
	logic             m_tvalid_q;
	logic             out_found_q;
	logic [31:0]      out_value_q;
	logic [1:0]       out_status_q;

	htlp_pkg::slot_t  mem [TABLE_DEPTH];
	htlp_pkg::slot_t  rd_q;
	htlp_pkg::slot_t  wdata;
	logic             mem_we;

	logic [63:0]      in_key_low;
	logic [63:0]      in_key_high;
	logic [4:0]       in_len;
	logic [31:0]      in_value;
	logic [63:0]      in_lo_m;
	logic [63:0]      in_hi_m;
	logic [127:0]     key_all;
	logic [7:0]       cur_byte;
	logic [31:0]      prod;
	logic [IDX_W-1:0] rem_next;
	logic             slot_match;
	logic             stop;

	assign in_key_low  = s_tdata[63:0];
	assign in_key_high = s_tdata[127:64];
	assign in_len      = s_tdata[132:128];
	assign in_value    = s_tdata[164:133];

	// Zero the key bytes at and beyond the length
	assign in_lo_m = in_key_low & byte_mask(in_len);
	assign in_hi_m = (in_len > 5'd8) ? (in_key_high & byte_mask(in_len - 5'd8)) : 64'd0;

	// Shared FNV step: fold in one byte, multiply by the prime
	assign key_all  = {hi_q, lo_q};
	assign cur_byte = key_all[{cnt_q[3:0], 3'b000} +: 8];
	assign prod     = (h_q ^ {24'd0, cur_byte}) * htlp_pkg::FNV_PRIME;

	// Reduce four hash bits per cycle into the running remainder
	always_comb begin
		logic [CNT_W-1:0] r;
		r = {1'b0, rem_q};
		for (int k = 0; k < 4; k++) begin
			r = {r[IDX_W-1:0], hs_q[31-k]};
			if (r >= DEPTH_C) begin
				r = r - DEPTH_C;
			end
		end
		rem_next = r[IDX_W-1:0];
	end

	// Probe decision on the row just read
	assign slot_match = (rd_q.hash == h_q) && (rd_q.key_length == len_q) &&
	                    (rd_q.key_low == lo_q) && (rd_q.key_high == hi_q);
	assign stop = (rd_q.value == 32'd0) || slot_match;

	// Write port: clearing sweep or a committed set
	assign mem_we = (state_q == S_CLEAR) ||
	                ((state_q == S_CHK) && stop && (op_q == htlp_pkg::OP_SET));
	always_comb begin
		wdata = '0;
		if (state_q != S_CLEAR) begin
			wdata.value      = val_q;
			wdata.key_high   = hi_q;
			wdata.key_low    = lo_q;
			wdata.key_length = len_q;
			wdata.hash       = h_q;
		end
	end

	// Row memory, registered read at the probe index
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q[IDX_W-1:0]] <= wdata;
		end
		rd_q <= mem[idx_q[IDX_W-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			idx_q        <= '0;
			cnt_q        <= '0;
			mcnt_q       <= '0;
			rem_q        <= '0;
			hs_q         <= '0;
			op_q         <= htlp_pkg::OP_GET;
			lo_q         <= '0;
			hi_q         <= '0;
			len_q        <= '0;
			val_q        <= '0;
			h_q          <= '0;
			res_found_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= htlp_pkg::ST_OK;
			m_tvalid_q   <= 1'b0;
			out_found_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= htlp_pkg::ST_OK;
		end else begin
			// Raise the response when one is loaded, drop it once it is taken
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST_C) begin
						state_q <= S_IDLE;
					end
					idx_q <= idx_q + 1'b1;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q         <= s_tuser;
						lo_q         <= in_lo_m;
						hi_q         <= in_hi_m;
						len_q        <= in_len;
						val_q        <= in_value;
						h_q          <= htlp_pkg::FNV_OFFSET;
						cnt_q        <= '0;
						res_found_q  <= 1'b0;
						res_value_q  <= '0;
						res_status_q <= htlp_pkg::ST_OK;
						if (s_tuser == htlp_pkg::OP_SET && in_value == 32'd0) begin
							res_status_q <= htlp_pkg::ST_ZERO;
							state_q      <= S_DONE;
						end else if (in_len > htlp_pkg::MAX_KEY_BYTES) begin
							if (s_tuser == htlp_pkg::OP_SET) begin
								res_status_q <= htlp_pkg::ST_LONG;
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (cnt_q == len_q) begin
						if (POW2) begin
							idx_q   <= {1'b0, h_q[IDX_W-1:0]};
							state_q <= S_RD;
						end else begin
							hs_q    <= h_q;
							rem_q   <= '0;
							mcnt_q  <= '0;
							state_q <= S_MOD;
						end
					end else begin
						h_q   <= prod;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MOD: begin
					rem_q  <= rem_next;
					hs_q   <= {hs_q[27:0], 4'd0};
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'd7) begin
						idx_q   <= {1'b0, rem_next};
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (stop) begin
						if (op_q == htlp_pkg::OP_GET) begin
							res_found_q <= (rd_q.value != 32'd0);
							res_value_q <= rd_q.value;
						end
						state_q <= S_DONE;
					end else if (idx_q == LAST_C) begin
						if (op_q == htlp_pkg::OP_SET) begin
							res_status_q <= htlp_pkg::ST_FULL;
						end
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						out_found_q  <= res_found_q;
						out_value_q  <= res_value_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_status_q, out_value_q, out_found_q};

	// Checks
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_CHK))
		else $error("table written outside clear or commit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CHK) |-> (idx_q < DEPTH_C))
		else $error("probe index past table end");

	a_hash_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HASH) |-> (cnt_q <= len_q && len_q <= htlp_pkg::MAX_KEY_BYTES))
		else $error("hash byte count out of range");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(out_found_q && out_status_q != htlp_pkg::ST_OK))
		else $error("found response with error status");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("request taken but sequencer stayed idle");

endmodule
